FILE: rtl/psht_pkg.sv
package psht_pkg;

   // table geometry, capacity is a power of two so the home slot is a bit-select
   localparam int CAPACITY   = 1024;
   localparam int IDX_W      = $clog2(CAPACITY);
   localparam int CNT_W      = $clog2(CAPACITY + 1);
   localparam int ADDR_SHIFT = 14;

   localparam int OP_W     = 2;
   localparam int KEY_W    = 64;
   localparam int SIZE_W   = 32;
   localparam int STATUS_W = 2;

   typedef enum logic [OP_W-1:0] {
      OP_INSERT = 2'd0,
      OP_REMOVE = 2'd1,
      OP_FIND   = 2'd2,
      OP_UNUSED = 2'd3
   } req_op_type;

   typedef enum logic [STATUS_W-1:0] {
      ST_OK        = 2'd0,
      ST_NOT_FOUND = 2'd1,
      ST_FULL      = 2'd2
   } rsp_status_type;

   typedef enum logic [1:0] {
      S_CLEAR,
      S_IDLE,
      S_PROBE
   } ctrl_state_type;

   typedef struct packed {
      logic              valid;
      logic [KEY_W-1:0]  key;
      logic [SIZE_W-1:0] size;
   } slot_row_type;

   typedef struct packed {
      logic             en;
      logic [IDX_W-1:0] addr;
      slot_row_type     row;
   } slot_wr_type;

endpackage

FILE: rtl/psht_slot_store.sv
module psht_slot_store (
   input  logic                        clock,
   input  psht_pkg::slot_wr_type       wr,
   input  logic [psht_pkg::IDX_W-1:0]  rd_addr,
   output psht_pkg::slot_row_type      rd_row
);
   import psht_pkg::*;

   // one row per slot: valid, key and size together
   slot_row_type slot_mem_ff [CAPACITY];
   slot_row_type rd_row_ff;

   always_ff @(posedge clock) begin
      if (wr.en) begin
         slot_mem_ff[wr.addr] <= wr.row;
      end
      rd_row_ff <= slot_mem_ff[rd_addr];
   end

   assign rd_row = rd_row_ff;

endmodule

FILE: rtl/psht_probe_ctrl.sv
module psht_probe_ctrl (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           start,
   output logic                           busy,
   input  logic [psht_pkg::OP_W-1:0]      req_type,
   input  logic [psht_pkg::KEY_W-1:0]     req_key,
   input  logic [psht_pkg::SIZE_W-1:0]    req_alloc_size,
   output logic                           rsp_valid,
   output logic [psht_pkg::SIZE_W-1:0]    rsp_found_size,
   output logic [psht_pkg::STATUS_W-1:0]  rsp_status,
   output logic [psht_pkg::CNT_W-1:0]     rsp_entry_count,
   output logic [psht_pkg::IDX_W-1:0]     rd_addr,
   input  psht_pkg::slot_row_type         rd_row,
   output psht_pkg::slot_wr_type          wr
);
   import psht_pkg::*;

   ctrl_state_type      state_ff, state_in;
   logic [IDX_W-1:0]    idx_ff, idx_in;
   logic [IDX_W-1:0]    probe_ff, probe_in;
   logic [CNT_W-1:0]    occ_ff, occ_in;
   logic [OP_W-1:0]     op_ff, op_in;
   logic [KEY_W-1:0]    key_ff, key_in;
   logic [SIZE_W-1:0]   size_ff, size_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic [SIZE_W-1:0]   rsp_size_ff, rsp_size_in;
   logic [STATUS_W-1:0] rsp_status_ff, rsp_status_in;
   logic [CNT_W-1:0]    rsp_count_ff, rsp_count_in;
   logic                last_probe;
   logic                key_hit;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         idx_ff       <= '0;
         probe_ff     <= '0;
         occ_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         idx_ff       <= idx_in;
         probe_ff     <= probe_in;
         occ_ff       <= occ_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff         <= op_in;
      key_ff        <= key_in;
      size_ff       <= size_in;
      rsp_size_ff   <= rsp_size_in;
      rsp_status_ff <= rsp_status_in;
      rsp_count_ff  <= rsp_count_in;
   end

   assign last_probe = (probe_ff == IDX_W'(CAPACITY - 1));
   assign key_hit    = (rd_row.key == key_ff);

   always_comb begin
      state_in      = state_ff;
      idx_in        = idx_ff;
      probe_in      = probe_ff;
      occ_in        = occ_ff;
      op_in         = op_ff;
      key_in        = key_ff;
      size_in       = size_ff;
      rsp_valid_in  = 1'b0;
      rsp_size_in   = rsp_size_ff;
      rsp_status_in = rsp_status_ff;
      wr            = '0;

      case (state_ff)
         S_CLEAR: begin
            // sweep every row to invalid after reset
            wr.en   = 1'b1;
            wr.addr = idx_ff;
            if (idx_ff == IDX_W'(CAPACITY - 1)) begin
               idx_in   = '0;
               state_in = S_IDLE;
            end else begin
               idx_in = idx_ff + IDX_W'(1);
            end
         end

         S_IDLE: begin
            if (start) begin
               op_in       = req_type;
               key_in      = req_key;
               size_in     = req_alloc_size;
               idx_in      = req_key[ADDR_SHIFT +: IDX_W];
               probe_in    = '0;
               rsp_size_in = '0;
               if (req_type == OP_INSERT && occ_ff >= CNT_W'(CAPACITY)) begin
                  rsp_valid_in  = 1'b1;
                  rsp_status_in = ST_FULL;
               end else if (req_type == OP_INSERT || req_type == OP_REMOVE ||
                            req_type == OP_FIND) begin
                  state_in = S_PROBE;
               end else begin
                  // unused request code: no table change
                  rsp_valid_in  = 1'b1;
                  rsp_status_in = ST_OK;
               end
            end
         end

         S_PROBE: begin
            case (op_ff)
               OP_INSERT: begin
                  if (!rd_row.valid) begin
                     wr.en         = 1'b1;
                     wr.addr       = idx_ff;
                     wr.row.valid  = 1'b1;
                     wr.row.key    = key_ff;
                     wr.row.size   = size_ff;
                     occ_in        = occ_ff + CNT_W'(1);
                     rsp_valid_in  = 1'b1;
                     rsp_status_in = ST_OK;
                     state_in      = S_IDLE;
                  end else if (last_probe) begin
                     rsp_valid_in  = 1'b1;
                     rsp_status_in = ST_FULL;
                     state_in      = S_IDLE;
                  end else begin
                     idx_in   = idx_ff + IDX_W'(1);
                     probe_in = probe_ff + IDX_W'(1);
                  end
               end

               OP_REMOVE, OP_FIND: begin
                  if (!rd_row.valid) begin
                     rsp_valid_in  = 1'b1;
                     rsp_status_in = ST_NOT_FOUND;
                     state_in      = S_IDLE;
                  end else if (key_hit) begin
                     rsp_valid_in  = 1'b1;
                     rsp_status_in = ST_OK;
                     state_in      = S_IDLE;
                     if (op_ff == OP_FIND) begin
                        rsp_size_in = rd_row.size;
                     end else begin
                        // no tombstone, the row simply goes invalid
                        wr.en        = 1'b1;
                        wr.addr      = idx_ff;
                        wr.row.valid = 1'b0;
                        wr.row.key   = rd_row.key;
                        wr.row.size  = rd_row.size;
                        if (occ_ff != '0) begin
                           occ_in = occ_ff - CNT_W'(1);
                        end
                     end
                  end else if (last_probe) begin
                     rsp_valid_in  = 1'b1;
                     rsp_status_in = ST_NOT_FOUND;
                     state_in      = S_IDLE;
                  end else begin
                     idx_in   = idx_ff + IDX_W'(1);
                     probe_in = probe_ff + IDX_W'(1);
                  end
               end

               default: begin
                  rsp_valid_in  = 1'b1;
                  rsp_status_in = ST_OK;
                  state_in      = S_IDLE;
               end
            endcase
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase

      rsp_count_in = occ_in;
   end

   // read runs one slot ahead so the next row is there when the probe needs it
   assign rd_addr         = idx_in;
   assign busy            = (state_ff != S_IDLE);
   assign rsp_valid       = rsp_valid_ff;
   assign rsp_found_size  = rsp_size_ff;
   assign rsp_status      = rsp_status_ff;
   assign rsp_entry_count = rsp_count_ff;

endmodule

FILE: rtl/pointer_size_hash_table_core.sv
// channel      | ports                                         | handshake
// request      | req_type, req_key, req_alloc_size             | start high, busy low
// response     | rsp_found_size, rsp_status, rsp_entry_count   | rsp_valid, one cycle
//
// a transaction probes P slots, P from 1 to 1024, through the single slot store read port,
// which the probe loop visits once per cycle
// full inserts and unused request codes answer in the cycle after start without probing
// after reset a clearing pass invalidates every slot, busy held high
// the response sits on the rsp_ ports for one cycle only, the receiver cannot stall
module pointer_size_hash_table_core (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           start,
   output logic                           busy,
   input  logic [psht_pkg::OP_W-1:0]      req_type,
   input  logic [psht_pkg::KEY_W-1:0]     req_key,
   input  logic [psht_pkg::SIZE_W-1:0]    req_alloc_size,
   output logic                           rsp_valid,
   output logic [psht_pkg::SIZE_W-1:0]    rsp_found_size,
   output logic [psht_pkg::STATUS_W-1:0]  rsp_status,
   output logic [psht_pkg::CNT_W-1:0]     rsp_entry_count
);
   import psht_pkg::*;

   // slot store read and write between the sequencer and the memory
   logic [IDX_W-1:0] rd_addr;
   slot_row_type     rd_row;
   slot_wr_type      wr;

   // probe sequencer: home slot, linear walk, compare, count of occupied slots
   psht_probe_ctrl u_probe_ctrl (
      .clock           (clock),
      .reset           (reset),
      .start           (start),
      .busy            (busy),
      .req_type        (req_type),
      .req_key         (req_key),
      .req_alloc_size  (req_alloc_size),
      .rsp_valid       (rsp_valid),
      .rsp_found_size  (rsp_found_size),
      .rsp_status      (rsp_status),
      .rsp_entry_count (rsp_entry_count),
      .rd_addr         (rd_addr),
      .rd_row          (rd_row),
      .wr              (wr)
   );

   // single-port-write, registered-read slot memory
   psht_slot_store u_slot_store (
      .clock   (clock),
      .wr      (wr),
      .rd_addr (rd_addr),
      .rd_row  (rd_row)
   );

   // a response only ever appears once the sequencer is back at rest
   a_rsp_when_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !busy)
      else $error("response strobed while sequencer busy");

   // an unused request code answers ok in the very next cycle
   a_unused_code: assert property (@(posedge clock) disable iff (reset)
      (start && !busy && req_type == OP_UNUSED) |=> (rsp_valid && rsp_status == ST_OK))
      else $error("unused request code not answered at once");

   // a full reply only arises once every slot is occupied
   a_full_count: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_status == ST_FULL) |-> (rsp_entry_count == CNT_W'(CAPACITY)))
      else $error("table full reported below capacity");

   // the occupied count never exceeds the table size
   a_count_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_entry_count <= CNT_W'(CAPACITY)))
      else $error("entry count beyond capacity");

   // no write reaches the memory while the sequencer is at rest
   a_no_idle_write: assert property (@(posedge clock) disable iff (reset)
      !busy |-> !wr.en)
      else $error("slot write while idle");

endmodule
